FILE: rtl/core/cnv2d_pkg.sv
// Package for the 2D zero-padded convolution block.
// Holds sizes, mode and register codes, and the types shared by front, queue and back.
// No dependencies.
package cnv2d_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned KMAX      = 5;
  localparam int unsigned NCOEF     = KMAX * KMAX;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W     = 11;
  localparam int unsigned HGT_W     = 16;
  localparam int unsigned KSZ_W     = 3;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned CI_W      = 5;
  localparam int unsigned RES_W     = 36;
  localparam int unsigned OROW_W    = 16;
  localparam int unsigned OCOL_W    = 10;
  localparam int unsigned ROW_W     = HGT_W + 1;
  localparam int unsigned P_W       = $clog2((2 ** HGT_W) * MAX_WIDTH + KMAX * MAX_WIDTH);
  localparam int unsigned LANES     = KMAX - 1;
  localparam int unsigned LINE_W    = LANES * PIX_W;
  localparam int unsigned PROD_W    = 2 * PIX_W;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_COEF  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [1:0] REG_IMG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_KERN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_KERN_HEIGHT = 2'd3;

  typedef enum logic {
    OP_COEF = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic [COL_W:0]       w;
    logic [HGT_W-1:0]     h;
    logic [KSZ_W-1:0]     kw;
    logic [KSZ_W-1:0]     kh;
  } cfg_t;

  typedef struct packed {
    logic                 last;
    logic [OROW_W-1:0]    out_row;
    logic [COL_W-1:0]     out_col;
  } meta_t;

  typedef struct packed {
    op_e                  op;
    logic signed [PIX_W-1:0] value;
    logic [CI_W-1:0]      coef_index;
    logic [COL_W-1:0]     col;
    logic                 emit;
    meta_t                meta;
    logic [KMAX-1:0]      row_ok;
    logic [KMAX-1:0]      col_ok;
  } item_t;

endpackage

FILE: rtl/core/cnv2d_if.sv
// Stream interfaces of the 2D convolution block: request in, result out.
// Depends on cnv2d_pkg for field widths.
interface cnv2d_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           mode;
  logic signed [cnv2d_pkg::PIX_W-1:0]   value;
  logic [cnv2d_pkg::CI_W-1:0]           coef_index;
  modport source (output valid, mode, value, coef_index, input ready);
  modport sink (input valid, mode, value, coef_index, output ready);
endinterface

interface cnv2d_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cnv2d_pkg::RES_W-1:0]   result;
  logic [cnv2d_pkg::OROW_W-1:0]         out_row;
  logic [cnv2d_pkg::OCOL_W-1:0]         out_col;
  logic                                 last;
  modport source (output valid, result, out_row, out_col, last, input ready);
  modport sink (input valid, result, out_row, out_col, last, output ready);
endinterface

FILE: rtl/core/cnv2d_front.sv
// Front end: accepts requests, tracks frame position and classifies each request.
// Pushes coefficient loads and ticks with padding masks into the queue. Uses cnv2d_pkg.
module cnv2d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnv2d_pkg::cfg_t    cfg_i,
  input  logic               restart_i,
  cnv2d_in_if.sink           in_if,
  input  logic               full_i,
  output logic               push_o,
  output cnv2d_pkg::item_t   item_o
);
  import cnv2d_pkg::*;

  logic [P_W-1:0]    pos_q, pos_d, delay;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  logic [KSZ_W-1:0]  dr, dc;
  logic              accept, tick, emit, last;
  logic [ROW_W+1:0]  rr [KMAX];
  logic [COL_W+1:0]  cc [KMAX];

  assign in_if.ready = !full_i;

  always_comb begin
    dr     = cfg_i.kh - KSZ_W'(1) - (cfg_i.kh >> 1);
    dc     = cfg_i.kw - KSZ_W'(1) - (cfg_i.kw >> 1);
    delay  = P_W'(dr) * P_W'(cfg_i.w) + P_W'(dc);
    accept = in_if.valid && in_if.ready;
    tick   = (in_if.mode == MODE_PIXEL) || (in_if.mode == MODE_FLUSH);
    emit   = pos_q >= delay;
    last   = emit && (out_row_q == cfg_i.h - OROW_W'(1))
             && ({1'b0, out_col_q} == cfg_i.w - (COL_W + 1)'(1));
    push_o = accept && (tick || ((in_if.mode == MODE_COEF)
             && (in_if.coef_index < CI_W'(NCOEF))));

    item_o.op         = tick ? OP_TICK : OP_COEF;
    item_o.value      = (!tick || ((in_if.mode == MODE_PIXEL) && (in_row_q < ROW_W'(cfg_i.h))))
                        ? in_if.value : '0;
    item_o.coef_index = in_if.coef_index;
    item_o.col        = in_col_q;
    item_o.emit       = emit;
    item_o.meta.last    = last;
    item_o.meta.out_row = out_row_q;
    item_o.meta.out_col = out_col_q;
    for (int a = 0; a < KMAX; a++) begin
      rr[a] = (ROW_W + 2)'(out_row_q) + (ROW_W + 2)'(cfg_i.kh) - (ROW_W + 2)'(a + 1)
              - (ROW_W + 2)'(cfg_i.kh >> 1);
      cc[a] = (COL_W + 2)'(out_col_q) + (COL_W + 2)'(cfg_i.kw) - (COL_W + 2)'(a + 1)
              - (COL_W + 2)'(cfg_i.kw >> 1);
      item_o.row_ok[a] = (KSZ_W'(a) < cfg_i.kh) && !rr[a][ROW_W+1]
                         && (rr[a][ROW_W:0] < (ROW_W + 1)'(cfg_i.h));
      item_o.col_ok[a] = (KSZ_W'(a) < cfg_i.kw) && !cc[a][COL_W+1]
                         && (cc[a][COL_W:0] < cfg_i.w);
    end

    pos_d     = pos_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    priority if (restart_i || (accept && tick && last)) begin
      pos_d     = '0;
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept && tick) begin
      pos_d = pos_q + P_W'(1);
      if ({1'b0, in_col_q} == cfg_i.w - (COL_W + 1)'(1)) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (emit) begin
        if ({1'b0, out_col_q} == cfg_i.w - (COL_W + 1)'(1)) begin
          out_col_d = '0;
          out_row_d = out_row_q + OROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      pos_q     <= pos_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

FILE: rtl/core/cnv2d_fifo.sv
// Short queue between the front end and the compute back end.
// Holds classified items. Uses cnv2d_pkg.
module cnv2d_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cnv2d_pkg::item_t   item_i,
  output logic               full_o,
  input  logic               pop_i,
  output cnv2d_pkg::item_t   item_o,
  output logic               empty_o
);
  import cnv2d_pkg::*;

  item_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

FILE: rtl/core/cnv2d_back.sv
// Back end: line memory, window, coefficient store, multipliers and adder tree.
// Pops items from the queue and drives the result register. Uses cnv2d_pkg.
module cnv2d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnv2d_pkg::cfg_t    cfg_i,
  input  logic               empty_i,
  input  cnv2d_pkg::item_t   item_i,
  output logic               pop_o,
  cnv2d_out_if.source        out_if
);
  import cnv2d_pkg::*;

  logic                     en, wr_en;
  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  item_t                    s1_q, s2_q;
  meta_t                    s3_q, s4_q, out_q;
  logic [LINE_W-1:0]        line_mem [MAX_WIDTH];
  logic [LINE_W-1:0]        rd_q, wdata;
  logic signed [PIX_W-1:0]  tap [KMAX];
  logic signed [PIX_W-1:0]  win_q [KMAX][KMAX];
  logic signed [PIX_W-1:0]  coef_q [NCOEF];
  logic signed [PROD_W-1:0] prod_d [KMAX][KMAX];
  logic signed [PROD_W-1:0] prod_q [KMAX][KMAX];
  logic signed [RES_W-1:0]  rsum_d [KMAX];
  logic signed [RES_W-1:0]  rsum_q [KMAX];
  logic signed [RES_W-1:0]  total_d, res_q;

  assign en    = !out_v_q || out_if.ready;
  assign pop_o = en && !empty_i;
  assign wr_en = en && s1_v_q && (s1_q.op == OP_TICK);
  assign wdata = {rd_q[LINE_W-PIX_W-1:0], s1_q.value};

  always_comb begin
    tap[0] = s1_q.value;
    for (int a = 1; a < KMAX; a++) begin
      tap[a] = rd_q[(a - 1) * PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_q.col] <= wdata;
    end
    if (en) begin
      rd_q <= (wr_en && (s1_q.col == item_i.col)) ? wdata : line_mem[item_i.col];
    end
  end

  always_comb begin
    int ci;
    for (int a = 0; a < KMAX; a++) begin
      for (int b = 0; b < KMAX; b++) begin
        ci = (int'(cfg_i.kh) - 1 - a) * int'(cfg_i.kw) + int'(cfg_i.kw) - 1 - b;
        if (s2_q.row_ok[a] && s2_q.col_ok[b]) begin
          prod_d[a][b] = PROD_W'(win_q[a][b] * coef_q[CI_W'(ci)]);
        end else begin
          prod_d[a][b] = '0;
        end
      end
    end
    for (int a = 0; a < KMAX; a++) begin
      rsum_d[a] = '0;
      for (int b = 0; b < KMAX; b++) begin
        rsum_d[a] = rsum_d[a] + RES_W'(prod_q[a][b]);
      end
    end
    total_d = '0;
    for (int a = 0; a < KMAX; a++) begin
      total_d = total_d + rsum_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= item_i;
      s2_q  <= s1_q;
      s3_q  <= s2_q.meta;
      s4_q  <= s3_q;
      out_q <= s4_q;
      res_q <= total_d;
      prod_q <= prod_d;
      rsum_q <= rsum_d;
      if (s1_v_q && (s1_q.op == OP_TICK)) begin
        for (int a = 0; a < KMAX; a++) begin
          win_q[a][0] <= tap[a];
          for (int b = 1; b < KMAX; b++) begin
            win_q[a][b] <= win_q[a][b-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int n = 0; n < NCOEF; n++) begin
        coef_q[n] <= '0;
      end
    end else if (en) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q && (s2_q.op == OP_TICK) && s2_q.emit;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
      if (s2_v_q && (s2_q.op == OP_COEF)) begin
        coef_q[s2_q.coef_index] <= s2_q.value;
      end
    end
  end

  assign out_if.valid   = out_v_q;
  assign out_if.result  = res_q;
  assign out_if.out_row = out_q.out_row;
  assign out_if.out_col = OCOL_W'(out_q.out_col);
  assign out_if.last    = out_q.last;

endmodule

FILE: rtl/core/conv2d_zero_padded.sv
// Same-size 2D correlation with zero padding over a raster pixel stream, Q8.8 kernels.
// One request per clock sustained unless stalled: each pixel or flush tick makes one read
// and one write of the single 1024 x 64-bit line memory and one pass through 25 parallel
// multipliers. A result passes the queue, s1 to s4 and the output register after the tick
// ending its window, (kh-1-kh/2)*W + (kw-1-kw/2) ticks behind the pixel stream; flush ticks
// drain the tail. Coefficient loads flow in order with ticks. No clearing pass after reset.
// Top level: APB configuration registers, front end, queue and back end. Uses cnv2d_pkg.
module conv2d_zero_padded (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cnv2d_in_if.sink    in_if,
  cnv2d_out_if.source out_if
);
  import cnv2d_pkg::*;

  logic [WID_W-1:0] img_width_q;
  logic [HGT_W-1:0] img_height_q;
  logic [KSZ_W-1:0] kern_width_q, kern_height_q;
  logic             cfg_we, push, pop, full, empty;
  cfg_t             cfg;
  item_t            push_item, head_item;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q   <= WID_W'(10);
      img_height_q  <= HGT_W'(10);
      kern_width_q  <= KSZ_W'(3);
      kern_height_q <= KSZ_W'(3);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_IMG_WIDTH:   img_width_q   <= pwdata[WID_W-1:0];
        REG_IMG_HEIGHT:  img_height_q  <= pwdata[HGT_W-1:0];
        REG_KERN_WIDTH:  kern_width_q  <= pwdata[KSZ_W-1:0];
        REG_KERN_HEIGHT: kern_height_q <= pwdata[KSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMG_WIDTH:   prdata = 32'(img_width_q);
      REG_IMG_HEIGHT:  prdata = 32'(img_height_q);
      REG_KERN_WIDTH:  prdata = 32'(kern_width_q);
      REG_KERN_HEIGHT: prdata = 32'(kern_height_q);
      default:         prdata = '0;
    endcase
    priority if (img_width_q == '0) begin
      cfg.w = (COL_W + 1)'(1);
    end else if (WID_W'(img_width_q) > WID_W'(MAX_WIDTH)) begin
      cfg.w = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      cfg.w = (COL_W + 1)'(img_width_q);
    end
    cfg.h = (img_height_q == '0) ? HGT_W'(1) : img_height_q;
    priority if (kern_width_q == '0) begin
      cfg.kw = KSZ_W'(1);
    end else if (kern_width_q > KSZ_W'(KMAX)) begin
      cfg.kw = KSZ_W'(KMAX);
    end else begin
      cfg.kw = kern_width_q;
    end
    priority if (kern_height_q == '0) begin
      cfg.kh = KSZ_W'(1);
    end else if (kern_height_q > KSZ_W'(KMAX)) begin
      cfg.kh = KSZ_W'(KMAX);
    end else begin
      cfg.kh = kern_height_q;
    end
  end

  cnv2d_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (cfg_we),
    .in_if     (in_if),
    .full_i    (full),
    .push_o    (push),
    .item_o    (push_item)
  );

  cnv2d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  cnv2d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_if  (out_if)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("queue push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("queue pop while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_if.valid && in_if.ready && (in_if.mode == MODE_FLUSH)) |-> push)
    else $error("flush tick dropped");
`endif

endmodule

FILE: dv/tb.sv
// Testbench for conv2d_zero_padded: a directed table, then random frames over many sizes.
// A built-in predictor of the padded correlation checks every result in order.
// Depends on cnv2d_pkg, cnv2d_if.sv and the RTL of conv2d_zero_padded.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cnv2d_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [RES_W-1:0] result;
    logic [OROW_W-1:0]       out_row;
    logic [OCOL_W-1:0]       out_col;
    logic                    last;
  } pix_out_t;

  typedef struct {
    logic [1:0]              mode;
    logic signed [PIX_W-1:0] value;
    logic [CI_W-1:0]         ci;
    bit                      typed;
    logic signed [RES_W-1:0] exp_result;
    logic                    exp_last;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  cnv2d_in_if  in_if();
  cnv2d_out_if out_if();

  conv2d_zero_padded DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  logic [WID_W-1:0] reg_w;
  logic [HGT_W-1:0] reg_h;
  logic [KSZ_W-1:0] reg_kw, reg_kh;
  logic signed [PIX_W-1:0] coefs [NCOEF];
  logic signed [PIX_W-1:0] frame_pix [int unsigned];
  int unsigned in_row, in_col, out_count;

  pix_out_t expected_pixels [$];
  int mismatches, results_seen, requests_sent, frames_done;
  int send_idle_pct, recv_stall_pct;

  function automatic int unsigned eff_w();
    return reg_w == 0 ? 1 : (reg_w > MAX_WIDTH ? MAX_WIDTH : reg_w);
  endfunction

  function automatic int unsigned eff_k(logic [KSZ_W-1:0] k);
    return k == 0 ? 1 : (k > KMAX ? KMAX : k);
  endfunction

  function automatic int unsigned frame_total();
    return eff_w() * (reg_h == 0 ? 1 : reg_h);
  endfunction

  function automatic int unsigned frame_delay();
    int unsigned kw, kh;
    kw = eff_k(reg_kw);
    kh = eff_k(reg_kh);
    return (kh - 1 - kh / 2) * eff_w() + (kw - 1 - kw / 2);
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    out_count = 0;
    frame_pix.delete();
  endfunction

  function automatic void predict_tick(input logic [1:0] mode, input logic signed [PIX_W-1:0] val,
                                       input logic [CI_W-1:0] ci, output bit emitted,
                                       output pix_out_t o);
    int unsigned w, h, kw, kh, total, pos, r, c;
    int rr, cc;
    longint acc;
    emitted = 0;
    o = '{default: '0};
    if (mode == MODE_COEF) begin
      if (ci < NCOEF) coefs[ci] = val;
      return;
    end
    if (mode != MODE_PIXEL && mode != MODE_FLUSH) return;
    w = eff_w();
    h = reg_h == 0 ? 1 : reg_h;
    kw = eff_k(reg_kw);
    kh = eff_k(reg_kh);
    total = w * h;
    pos = in_row * w + in_col;
    frame_pix[pos] = (mode == MODE_PIXEL && pos < total) ? val : '0;
    if (pos >= frame_delay()) begin
      r = out_count / w;
      c = out_count % w;
      acc = 0;
      for (int i = 0; i < kh; i++) begin
        for (int j = 0; j < kw; j++) begin
          rr = r + i - kh / 2;
          cc = c + j - kw / 2;
          if (rr >= 0 && rr < h && cc >= 0 && cc < w)
            acc += longint'(frame_pix[rr * w + cc]) * longint'(coefs[i * kw + j]);
        end
      end
      o.result = acc[RES_W-1:0];
      o.out_row = r[OROW_W-1:0];
      o.out_col = c[OCOL_W-1:0];
      o.last = (out_count + 1 >= total);
      emitted = 1;
      out_count++;
    end
    if (emitted && o.last) begin
      restart_frame();
      frames_done++;
    end else begin
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[conv2d_zero_padded] ERROR");
    $finish;
  end

  always @(negedge clk_i)
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    pix_out_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: exp none, got %0d r%0d c%0d l%0d", out_if.result,
                   out_if.out_row, out_if.out_col, out_if.last);
      end else begin
        e = expected_pixels.pop_front();
        if (out_if.result !== e.result || out_if.out_row !== e.out_row ||
            out_if.out_col !== e.out_col || out_if.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d r%0d c%0d l%0d, got %0d r%0d c%0d l%0d",
                     e.result, e.out_row, e.out_col, e.last, out_if.result,
                     out_if.out_row, out_if.out_col, out_if.last);
        end
      end
    end
  end

  task automatic send_req(input logic [1:0] mode, input logic signed [PIX_W-1:0] val,
                          input logic [CI_W-1:0] ci, output bit emitted, output pix_out_t o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_if.valid = 1;
    in_if.mode = mode;
    in_if.value = val;
    in_if.coef_index = ci;
    do @(posedge clk_i); while (!in_if.ready);
    predict_tick(mode, val, ci, emitted, o);
    if (emitted) expected_pixels.push_back(o);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] exp_rd;
    psel = 1;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    @(negedge clk_i);
    case (idx)
      REG_IMG_WIDTH:   exp_rd = 32'(val[WID_W-1:0]);
      REG_IMG_HEIGHT:  exp_rd = 32'(val[HGT_W-1:0]);
      default:         exp_rd = 32'(val[KSZ_W-1:0]);
    endcase
    if (prdata !== exp_rd) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d readback: exp %0d, got %0d", idx, exp_rd, prdata);
    end
    psel = 0;
    penable = 0;
    pwrite = 0;
    case (idx)
      REG_IMG_WIDTH:   reg_w = val[WID_W-1:0];
      REG_IMG_HEIGHT:  reg_h = val[HGT_W-1:0];
      REG_KERN_WIDTH:  reg_kw = val[KSZ_W-1:0];
      default:         reg_kh = val[KSZ_W-1:0];
    endcase
    restart_frame();
  endtask

  task automatic configure(input int w, input int h, input int kw, input int kh);
    drain();
    write_reg(REG_IMG_WIDTH, w);
    write_reg(REG_IMG_HEIGHT, h);
    write_reg(REG_KERN_WIDTH, kw);
    write_reg(REG_KERN_HEIGHT, kh);
  endtask

  function automatic logic signed [PIX_W-1:0] rand_val();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return PIX_W'(int'($urandom_range(511)) - 256);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic run_frame(input bit noisy);
    bit em;
    pix_out_t o;
    int unsigned total;
    total = frame_total();
    do begin
      if (noisy && $urandom_range(99) < 4)
        send_req(MODE_UNUSED, rand_val(), CI_W'($urandom), em, o);
      else if (noisy && $urandom_range(99) < 3)
        send_req(MODE_COEF, rand_val(), CI_W'($urandom), em, o);
      else if (in_row * eff_w() + in_col < total && !(noisy && $urandom_range(99) < 4))
        send_req(MODE_PIXEL, rand_val(), CI_W'($urandom), em, o);
      else
        send_req($urandom_range(1) ? MODE_FLUSH : MODE_PIXEL, rand_val(), CI_W'($urandom),
                 em, o);
    end while (!(em && o.last));
  endtask

  stim_row_t directed [24] = '{
    '{MODE_UNUSED, 16'sh1234, 5'd0,  0, 0, 0},
    '{MODE_COEF,   16'sh7fff, 5'd31, 0, 0, 0},
    '{MODE_PIXEL,  16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh8000, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh0001, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'shffff, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh8000, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh0000, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh8000, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh8000, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh7fff, 5'd0,  1, 0, 0},
    '{MODE_COEF,   16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_COEF,   16'sh8000, 5'd8,  0, 0, 0},
    '{MODE_COEF,   16'sh0100, 5'd4,  0, 0, 0},
    '{MODE_COEF,   16'shffff, 5'd24, 0, 0, 0},
    '{MODE_COEF,   16'sh0080, 5'd25, 0, 0, 0},
    '{MODE_FLUSH,  16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh8000, 5'd0,  0, 0, 0},
    '{MODE_PIXEL,  16'sh7fff, 5'd0,  0, 0, 0},
    '{MODE_UNUSED, 16'sh8000, 5'd31, 0, 0, 0},
    '{MODE_PIXEL,  16'sh0005, 5'd0,  0, 0, 0}
  };

  initial begin
    bit em;
    pix_out_t o;
    int ph;
    int target;
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 0;
    in_if.mode = '0;
    in_if.value = '0;
    in_if.coef_index = '0;
    out_if.ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reg_w = 10;
    reg_h = 10;
    reg_kw = 3;
    reg_kh = 3;
    foreach (coefs[i]) coefs[i] = '0;
    restart_frame();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      send_req(directed[i].mode, directed[i].value, directed[i].ci, em, o);
      if (directed[i].typed && (!em || o.result !== directed[i].exp_result ||
                                o.last !== directed[i].exp_last)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: exp %0d l%0d, predicted %0d l%0d (emitted %0d)", i,
                   directed[i].exp_result, directed[i].exp_last, o.result, o.last, em);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      configure($urandom_range(10), $urandom_range(6), $urandom_range(7), $urandom_range(7));
      for (int n = 0; n < NCOEF; n++)
        send_req(MODE_COEF, rand_val(), CI_W'(n), em, o);
      target = requests_sent + 125;
      while (requests_sent < target) begin
        run_frame(1);
        if ($urandom_range(2) == 0)
          configure($urandom_range(10), $urandom_range(6), $urandom_range(7),
                    $urandom_range(7));
      end
    end

    drain();
    $display("sent %0d requests, checked %0d results over %0d frames", requests_sent,
             results_seen, frames_done);
    $display("covered random sizes and kernels with idle, stall and mixed handshake phases");
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("[conv2d_zero_padded] OK");
    else
      $display("[conv2d_zero_padded] ERROR");
    $finish;
  end
endmodule
